// File: design/lisp_token_scanner_top_assert.svh
// Assertion macros shared by the token scanner RTL.
// Included by lts_queue and lts_back; depends on nothing else.
`ifndef LISP_TOKEN_SCANNER_TOP_ASSERT_SVH
`define LISP_TOKEN_SCANNER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTS_ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("lts: implication check failed");

// Consequent must hold in the cycle after the antecedent.
`define LTS_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("lts: next-cycle check failed");

`endif

// File: design/lts_pkg.sv
// Types and constants of the token scanner.
// Used by lts_front, lts_queue, lts_back and lisp_token_scanner_top; no dependencies.
`default_nettype none

package lts_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } char_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_offset;
        logic [16:0] token_length;
        logic [15:0] line_number;
        logic        last_result;
    } tok_item_t;

    // All tokens caused by one source byte, oldest in slot 0.
    typedef struct packed {
        logic [1:0]          count;
        tok_item_t [2:0]     tok;
    } bundle_t;

    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_NUMBER  = 5'd1;
    localparam logic [4:0] KIND_NAME    = 5'd2;
    localparam logic [4:0] KIND_QUOTE   = 5'd3;
    localparam logic [4:0] KIND_CONS    = 5'd4;
    localparam logic [4:0] KIND_CAR     = 5'd5;
    localparam logic [4:0] KIND_TRUE    = 5'd6;
    localparam logic [4:0] KIND_FALSE   = 5'd7;
    localparam logic [4:0] KIND_PLUS    = 5'd8;
    localparam logic [4:0] KIND_MINUS   = 5'd9;
    localparam logic [4:0] KIND_STAR    = 5'd10;
    localparam logic [4:0] KIND_SLASH   = 5'd11;
    localparam logic [4:0] KIND_TICK    = 5'd12;
    localparam logic [4:0] KIND_LPAREN  = 5'd13;
    localparam logic [4:0] KIND_RPAREN  = 5'd14;
    localparam logic [4:0] KIND_EQ      = 5'd15;
    localparam logic [4:0] KIND_EQEQ    = 5'd16;
    localparam logic [4:0] KIND_GT      = 5'd17;
    localparam logic [4:0] KIND_GE      = 5'd18;
    localparam logic [4:0] KIND_LT      = 5'd19;
    localparam logic [4:0] KIND_LE      = 5'd20;
    localparam logic [4:0] KIND_BANG    = 5'd21;
    localparam logic [4:0] KIND_NE      = 5'd22;
    localparam logic [4:0] KIND_STRING  = 5'd23;
    localparam logic [4:0] KIND_UNKNOWN = 5'd24;
    localparam logic [4:0] KIND_UNTERM  = 5'd25;

    // Keyword spellings, first byte in the most significant position.
    localparam logic [39:0] KW_QUOTE = 40'h71756F7465;
    localparam logic [39:0] KW_CONS  = 40'h00636F6E73;
    localparam logic [39:0] KW_CAR   = 40'h0000636172;
    localparam logic [39:0] KW_TRUE  = 40'h0074727565;
    localparam logic [39:0] KW_FALSE = 40'h66616C7365;

endpackage

`default_nettype wire

// File: design/lts_front.sv
// Front end of the token scanner: classifies each byte and builds its token bundle.
// Depends on lts_pkg.
`default_nettype none

module lts_front #(
    parameter int unsigned MAX_SOURCE_BYTES = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  lts_pkg::char_item_t item,
    output logic                wr_en,
    output lts_pkg::bundle_t    wr_data
);

    localparam int unsigned POS_W = $clog2(MAX_SOURCE_BYTES + 1);
    localparam int unsigned CMP_W = (POS_W > 17) ? POS_W + 1 : 18;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SOURCE_BYTES);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_FRAC,
        MODE_NAME,
        MODE_PEND,
        MODE_STRING,
        MODE_COMMENT
    } mode_t;

    mode_t             mode_reg, mode_next, mode_mid;
    logic [POS_W-1:0]  start_reg, start_next, start_mid;
    logic [POS_W-1:0]  pos_reg, pos_next, pos_inc;
    logic [15:0]       line_reg, line_next, line_mid;
    logic [39:0]       prefix_reg, prefix_next, prefix_mid;
    logic [2:0]        ncount_reg, ncount_next, ncount_mid;
    logic [7:0]        pend_reg, pend_next, pend_mid;

    logic [7:0]            c;
    logic                  fin;
    logic                  is_dig, is_let, again;
    logic [4:0]            op_kind;
    lts_pkg::tok_item_t    cand [4];
    logic [3:0]            cand_v;
    logic [1:0]            n;

    function automatic lts_pkg::tok_item_t make_token(
        input logic [4:0]       kind,
        input logic [POS_W-1:0] start,
        input logic [CMP_W-1:0] len,
        input logic [15:0]      line
    );
        logic [CMP_W-1:0]   s_ext;
        lts_pkg::tok_item_t t;
        s_ext = CMP_W'(start);
        t.token_kind   = kind;
        t.start_offset = (s_ext > CMP_W'(17'h0FFFF)) ? 16'hFFFF : s_ext[15:0];
        t.token_length = (len > CMP_W'(17'h1FFFF)) ? 17'h1FFFF : len[16:0];
        t.line_number  = line;
        t.last_result  = 1'b0;
        return t;
    endfunction

    function automatic logic [CMP_W-1:0] span(
        input logic [POS_W-1:0] stop,
        input logic [POS_W-1:0] start
    );
        return CMP_W'(stop) - CMP_W'(start);
    endfunction

    function automatic logic [4:0] name_kind(input logic [39:0] p, input logic [2:0] k);
        logic [4:0] r;
        r = lts_pkg::KIND_NAME;
        if (k == 3'd5 && p == lts_pkg::KW_QUOTE) r = lts_pkg::KIND_QUOTE;
        if (k == 3'd4 && p == lts_pkg::KW_CONS)  r = lts_pkg::KIND_CONS;
        if (k == 3'd3 && p == lts_pkg::KW_CAR)   r = lts_pkg::KIND_CAR;
        if (k == 3'd4 && p == lts_pkg::KW_TRUE)  r = lts_pkg::KIND_TRUE;
        if (k == 3'd5 && p == lts_pkg::KW_FALSE) r = lts_pkg::KIND_FALSE;
        return r;
    endfunction

    function automatic logic [4:0] single_op(input logic [7:0] b);
        logic [4:0] r;
        case (b)
            "+":     r = lts_pkg::KIND_PLUS;
            "-":     r = lts_pkg::KIND_MINUS;
            "*":     r = lts_pkg::KIND_STAR;
            "/":     r = lts_pkg::KIND_SLASH;
            "'":     r = lts_pkg::KIND_TICK;
            "(":     r = lts_pkg::KIND_LPAREN;
            ")":     r = lts_pkg::KIND_RPAREN;
            default: r = lts_pkg::KIND_EOF;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] cmp_kind(input logic [7:0] b, input logic two);
        logic [4:0] r;
        case (b)
            "=":     r = two ? lts_pkg::KIND_EQEQ : lts_pkg::KIND_EQ;
            ">":     r = two ? lts_pkg::KIND_GE   : lts_pkg::KIND_GT;
            "<":     r = two ? lts_pkg::KIND_LE   : lts_pkg::KIND_LT;
            default: r = two ? lts_pkg::KIND_NE   : lts_pkg::KIND_BANG;
        endcase
        return r;
    endfunction

    assign c       = item.ch;
    assign fin     = item.end_of_input;
    assign is_dig  = c inside {["0":"9"]};
    assign is_let  = (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
    assign op_kind = single_op(c);
    assign pos_inc = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;

    always_comb
    begin
        mode_mid   = mode_reg;
        start_mid  = start_reg;
        line_mid   = line_reg;
        prefix_mid = prefix_reg;
        ncount_mid = ncount_reg;
        pend_mid   = pend_reg;
        again      = 1'b0;
        cand_v     = 4'b0000;
        for (int i = 0; i < 4; i++)
        begin
            cand[i] = make_token(lts_pkg::KIND_EOF, pos_inc, '0, line_reg);
        end

        // Finish or extend the token in progress.
        case (mode_reg)
            MODE_INT:
            begin
                if (c == ".")
                begin
                    mode_mid = MODE_FRAC;
                end
                else if (!is_dig)
                begin
                    cand_v[0] = 1'b1;
                    cand[0]   = make_token(lts_pkg::KIND_NUMBER, start_reg,
                                           span(pos_reg, start_reg), line_reg);
                    again     = 1'b1;
                end
            end
            MODE_FRAC:
            begin
                if (!is_dig)
                begin
                    cand_v[0] = 1'b1;
                    cand[0]   = make_token(lts_pkg::KIND_NUMBER, start_reg,
                                           span(pos_reg, start_reg), line_reg);
                    again     = 1'b1;
                end
            end
            MODE_NAME:
            begin
                if (is_dig || is_let)
                begin
                    if (ncount_reg < 3'd5)
                    begin
                        prefix_mid = {prefix_reg[31:0], c};
                    end
                    if (ncount_reg < 3'd6)
                    begin
                        ncount_mid = ncount_reg + 3'd1;
                    end
                end
                else
                begin
                    cand_v[0] = 1'b1;
                    cand[0]   = make_token(name_kind(prefix_reg, ncount_reg), start_reg,
                                           span(pos_reg, start_reg), line_reg);
                    again     = 1'b1;
                end
            end
            MODE_PEND:
            begin
                cand_v[0] = 1'b1;
                if (c == "=")
                begin
                    cand[0]  = make_token(cmp_kind(pend_reg, 1'b1), start_reg,
                                          CMP_W'(2), line_reg);
                    mode_mid = MODE_IDLE;
                end
                else
                begin
                    cand[0] = make_token(cmp_kind(pend_reg, 1'b0), start_reg,
                                         CMP_W'(1), line_reg);
                    again   = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (c == "\"")
                begin
                    cand_v[0] = 1'b1;
                    cand[0]   = make_token(lts_pkg::KIND_STRING, start_reg,
                                           span(pos_reg, start_reg) + CMP_W'(1), line_reg);
                    mode_mid  = MODE_IDLE;
                end
            end
            MODE_COMMENT:
            begin
                again = (c == "\n");
            end
            default:
            begin
                again = 1'b1;
            end
        endcase

        // Rescan the byte as the start of something new.
        if (again)
        begin
            mode_mid = MODE_IDLE;
            if (c == " " || c == "\t" || c == "\r")
            begin
                mode_mid = MODE_IDLE;
            end
            else if (c == "\n")
            begin
                line_mid = (line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
            end
            else if (c == ";")
            begin
                mode_mid = MODE_COMMENT;
            end
            else if (is_dig)
            begin
                start_mid = pos_reg;
                mode_mid  = MODE_INT;
            end
            else if (is_let)
            begin
                start_mid  = pos_reg;
                mode_mid   = MODE_NAME;
                prefix_mid = {32'd0, c};
                ncount_mid = 3'd1;
            end
            else if (op_kind != lts_pkg::KIND_EOF)
            begin
                cand_v[1] = 1'b1;
                cand[1]   = make_token(op_kind, pos_reg, CMP_W'(1), line_reg);
            end
            else if (c == "=" || c == ">" || c == "<" || c == "!")
            begin
                if (fin)
                begin
                    cand_v[1] = 1'b1;
                    cand[1]   = make_token(cmp_kind(c, 1'b0), pos_reg, CMP_W'(1), line_reg);
                end
                else
                begin
                    start_mid = pos_reg;
                    pend_mid  = c;
                    mode_mid  = MODE_PEND;
                end
            end
            else if (c == "\"")
            begin
                start_mid = pos_reg;
                mode_mid  = MODE_STRING;
            end
            else
            begin
                cand_v[1] = 1'b1;
                cand[1]   = make_token(lts_pkg::KIND_UNKNOWN, pos_reg, CMP_W'(1), line_reg);
            end
        end

        // Close the source on its final byte.
        if (fin)
        begin
            case (mode_mid)
                MODE_INT, MODE_FRAC:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_token(lts_pkg::KIND_NUMBER, start_mid,
                                           span(pos_inc, start_mid), line_mid);
                end
                MODE_NAME:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_token(name_kind(prefix_mid, ncount_mid), start_mid,
                                           span(pos_inc, start_mid), line_mid);
                end
                MODE_STRING:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_token(lts_pkg::KIND_UNTERM, start_mid,
                                           span(pos_inc, start_mid), line_mid);
                end
                default:
                begin
                    cand_v[2] = 1'b0;
                end
            endcase
            cand_v[3] = 1'b1;
            cand[3]   = make_token(lts_pkg::KIND_EOF, pos_inc, '0, line_mid);
        end
    end

    // Pack up to three tokens in order; drop any beyond the third.
    always_comb
    begin
        n       = 2'd0;
        wr_data = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && n != 2'd3)
            begin
                wr_data.tok[n] = cand[i];
                n              = n + 2'd1;
            end
        end
        wr_data.count = n;
        wr_en         = accept && (n != 2'd0);
    end

    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        ncount_next = ncount_reg;
        pend_next   = pend_reg;
        if (accept)
        begin
            if (fin)
            begin
                mode_next   = MODE_IDLE;
                start_next  = '0;
                pos_next    = '0;
                line_next   = '0;
                prefix_next = '0;
                ncount_next = '0;
                pend_next   = '0;
            end
            else
            begin
                mode_next   = mode_mid;
                start_next  = start_mid;
                pos_next    = pos_inc;
                line_next   = line_mid;
                prefix_next = prefix_mid;
                ncount_next = ncount_mid;
                pend_next   = pend_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            start_reg  <= '0;
            pos_reg    <= '0;
            line_reg   <= '0;
            prefix_reg <= '0;
            ncount_reg <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            ncount_reg <= ncount_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

`default_nettype wire

// File: design/lts_queue.sv
// Bundle queue between the scanner front end and the token sequencer.
// Depends on lts_pkg and lisp_token_scanner_top_assert.svh.
`default_nettype none

`include "lisp_token_scanner_top_assert.svh"

module lts_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  lts_pkg::bundle_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output lts_pkg::bundle_t rd_data,
    output logic             nonempty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lts_pkg::bundle_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign nonempty = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LTS_ASSERT_IMPLY(a_no_write_when_full, clk, rst_n, wr_en, !full)
    `LTS_ASSERT_NEXT(a_count_tracks_write, clk, rst_n, wr_en && !rd_en,
        count_reg == $past(count_reg) + CNT_W'(1))

endmodule

`default_nettype wire

// File: design/lts_back.sv
// Token sequencer: unpacks bundles and presents one token at a time.
// Depends on lts_pkg and lisp_token_scanner_top_assert.svh.
`default_nettype none

`include "lisp_token_scanner_top_assert.svh"

module lts_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fifo_nonempty,
    input  lts_pkg::bundle_t    fifo_data,
    output logic                fifo_rd,
    output logic                empty,
    input  logic                pop,
    output lts_pkg::tok_item_t  token
);

    lts_pkg::bundle_t cur_reg, cur_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [1:0]       idx_reg, idx_next;
    logic             is_last, advance, load;

    assign is_last = ((idx_reg + 2'd1) == cur_reg.count);
    assign advance = pop && cur_valid_reg;
    assign load    = fifo_nonempty && (!cur_valid_reg || (advance && is_last));
    assign fifo_rd = load;
    assign empty   = !cur_valid_reg;

    always_comb
    begin
        token             = cur_reg.tok[idx_reg];
        token.last_result = is_last;
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cur_next       = fifo_data;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (advance && is_last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    `LTS_ASSERT_IMPLY(a_index_in_bundle, clk, rst_n, cur_valid_reg, idx_reg < cur_reg.count)
    `LTS_ASSERT_IMPLY(a_load_needs_data, clk, rst_n, fifo_rd, fifo_nonempty)

endmodule

`default_nettype wire

// File: design/lisp_token_scanner_top.sv
// Top level of the lisp token scanner: front end, bundle queue, token sequencer.
// Depends on lts_pkg, lts_front, lts_queue and lts_back.
//
//   channel  direction  handshake            payload
//   -------  ---------  -------------------  ----------------------------------
//   source   in         push / full          char_item (ch, end_of_input)
//   tokens   out        empty / pop          token (kind, start, length, line,
//                                            last_result)
//
// One source byte is accepted per cycle while the bundle queue has room.
// A byte yields zero to three tokens and tokens leave one per cycle while pop
// is held, so the output side sets the sustained rate when bytes yield many tokens.
// The first token of a byte is registered in the queue and then in the sequencer before it is on the output.
// Reset (rst_n low, asynchronous) returns to the start of a source and empties all.
// A stalled output fills the queue, and full then holds off the source.
`default_nettype none

module lisp_token_scanner_top #(
    // Byte offsets saturate at this value; sets the position counter width.
    parameter int unsigned MAX_SOURCE_BYTES = 65536,
    // Token bundles buffered between scanner and sequencer (2 to 16).
    parameter int unsigned QUEUE_DEPTH      = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lts_pkg::char_item_t char_item,
    output logic                empty,
    input  logic                pop,
    output lts_pkg::tok_item_t  token
);

    logic             accept;
    logic             q_wr_en;
    lts_pkg::bundle_t q_wr_data;
    logic             q_rd_en;
    lts_pkg::bundle_t q_rd_data;
    logic             q_nonempty;

    // Take a byte only when the queue can hold whatever it produces.
    assign accept = push && !full;

    // Classify the byte, advance scan state, build its token bundle.
    lts_front #(
        .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (char_item),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data)
    );

    // Hold bundles so that scanning and token delivery stall independently.
    lts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .full     (full),
        .rd_en    (q_rd_en),
        .rd_data  (q_rd_data),
        .nonempty (q_nonempty)
    );

    // Drain bundles one token per pop and flag the final token of each byte.
    lts_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_nonempty (q_nonempty),
        .fifo_data     (q_rd_data),
        .fifo_rd       (q_rd_en),
        .empty         (empty),
        .pop           (pop),
        .token         (token)
    );

endmodule

`default_nettype wire
